FILE: rtl/lom_pkg.sv
// ----------------------------------------------------------------------------
// lom_pkg
// Shared types and constants of the limit order matcher.
// ----------------------------------------------------------------------------
package lom_pkg;

    localparam int BookDepthDefault = 32;
    localparam int SymW    = 4;
    localparam int TraderW = 8;
    localparam int PriceW  = 32;
    localparam int QtyW    = 16;
    localparam int IdW     = 16;

    // result kinds
    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // status codes
    localparam logic [2:0] ST_FILLED    = 3'd0;
    localparam logic [2:0] ST_RESTED    = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // commands and sides
    localparam logic CMD_PLACE  = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;
    localparam logic SIDE_SELL  = 1'b1;

    typedef struct packed {
        logic [PriceW-1:0]  price;
        logic [QtyW-1:0]    qty;
        logic [TraderW-1:0] trader;
        logic [SymW-1:0]    sym;
        logic [IdW-1:0]     id;
    } t_entry;

endpackage

FILE: rtl/lom_cell.sv
// ----------------------------------------------------------------------------
// lom_cell
// One resting-order slot: load from the write port or take the neighbour.
// ----------------------------------------------------------------------------
module lom_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_wr,
    input  lom_pkg::t_entry i_wr_data,
    input  lom_pkg::t_entry i_next,
    output lom_pkg::t_entry o_q
);

    lom_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q <= i_wr_data;
        end else if (i_shift) begin
            r_q <= i_next;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/lom_book.sv
// ----------------------------------------------------------------------------
// lom_book
// Row of order cells; shifting moves every entry one place toward the head.
// ----------------------------------------------------------------------------
module lom_book #(
    parameter int BOOK_DEPTH = lom_pkg::BookDepthDefault,
    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_wr,
    input  logic [IW-1:0]   i_wr_pos,
    input  lom_pkg::t_entry i_wr_data,
    output lom_pkg::t_entry o_head
);

    lom_pkg::t_entry w_q [BOOK_DEPTH];

    for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
        lom_pkg::t_entry w_next;
        if (k < BOOK_DEPTH - 1) begin : g_mid
            assign w_next = w_q[k+1];
        end else begin : g_end
            assign w_next = w_q[k];
        end
        lom_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (i_shift),
            .i_wr      (i_wr && (i_wr_pos == IW'(k))),
            .i_wr_data (i_wr_data),
            .i_next    (w_next),
            .o_q       (w_q[k])
        );
    end

    assign o_head = w_q[0];

endmodule

FILE: rtl/limit_order_matcher.sv
// Sequence: a place walks the opposite book entry by entry, emitting its trades, then
// gives its finish result; a place of zero quantity goes straight to its finish result.
// A cancel walks the buy book and, if the order is not found there, the sell book, then
// answers. Every step holds while the result register is stalled. One item at a time:
// the next transfer is taken once the answer is loaded into the result register.
// Reset: both book counts clear, the next order id returns to one.
// ----------------------------------------------------------------------------
// limit_order_matcher
// Two-sided limit order book with price-crossing matcher and cancel.
// ----------------------------------------------------------------------------
module limit_order_matcher #(
    parameter int BOOK_DEPTH = lom_pkg::BookDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic        i_side,
    input  logic [3:0]  i_symbol_index,
    input  logic [31:0] i_limit_price,
    input  logic [15:0] i_order_quantity,
    input  logic [7:0]  i_trader_id,
    input  logic [15:0] i_cancel_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_buyer_id,
    output logic [7:0]  o_seller_id,
    output logic [3:0]  o_trade_symbol,
    output logic [31:0] o_trade_price,
    output logic [15:0] o_shares,
    output logic [15:0] o_assigned_id,
    output logic [2:0]  o_status,
    output logic        o_last_item
);

    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]  r_state;
    logic        r_cmd, r_side, r_phase, r_found;
    logic [3:0]  r_sym, r_csym;
    logic [31:0] r_price;
    logic [15:0] r_remain, r_id, r_cid, r_cqty, r_next_id;
    logic [7:0]  r_trader;
    logic [CW-1:0] r_u, r_k, r_cnt_b, r_cnt_s;

    // result register
    logic        r_ov;
    logic [1:0]  r_kind;
    logic [7:0]  r_buyer, r_seller;
    logic [3:0]  r_osym;
    logic [31:0] r_oprice;
    logic [15:0] r_oshares, r_oid;
    logic [2:0]  r_ostatus;
    logic        r_olast;

    logic out_free, accept, walk_sell, step, at_end, match, keep, emit_trade;
    lom_pkg::t_entry head_b, head_s, head, kept, append;
    logic [15:0] n_t, n_left;
    logic [CW-1:0] own_cnt;
    logic [CW-1:0] wpos;

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // the walked book: opposite side on a place, buy then sell on a cancel
    assign walk_sell = (r_cmd == lom_pkg::CMD_CANCEL) ? r_phase : (r_side == lom_pkg::SIDE_BUY);
    assign head      = walk_sell ? head_s : head_b;
    assign step      = (r_state == S_WALK) && out_free;
    assign at_end    = (r_u == '0);

    always_comb begin
        match = 1'b0;
        if (r_cmd == lom_pkg::CMD_CANCEL) begin
            match = !r_found && (head.id == r_cid) && (head.trader == r_trader);
        end else begin
            match = (head.sym == r_sym) && (head.qty != '0) && (r_remain != '0)
                && ((r_side == lom_pkg::SIDE_SELL) ? (head.price >= r_price)
                                                   : (head.price <= r_price));
        end
    end

    assign n_t        = (r_remain < head.qty) ? r_remain : head.qty;
    assign n_left     = head.qty - n_t;
    assign emit_trade = step && !at_end && match && (r_cmd == lom_pkg::CMD_PLACE);
    // drop a filled or cancelled entry, keep everything else
    assign keep = !match || ((r_cmd == lom_pkg::CMD_PLACE) && (n_left != '0));

    always_comb begin
        kept = head;
        if (match && (r_cmd == lom_pkg::CMD_PLACE)) begin
            kept.qty = n_left;
        end
    end

    assign wpos    = r_u - CW'(1) + r_k;
    assign own_cnt = (r_side == lom_pkg::SIDE_SELL) ? r_cnt_s : r_cnt_b;

    always_comb begin
        append.price  = r_price;
        append.qty    = r_remain;
        append.trader = r_trader;
        append.sym    = r_sym;
        append.id     = r_id;
    end

    // append of a remainder in the finish step
    logic do_rest;
    assign do_rest = (r_state == S_FINISH) && out_free && (r_cmd == lom_pkg::CMD_PLACE)
                  && (r_remain != '0) && (own_cnt < CW'(BOOK_DEPTH));

    logic b_shift, s_shift, b_wr, s_wr;
    logic [IW-1:0] b_pos, s_pos;
    assign b_shift = step && !at_end && !walk_sell;
    assign s_shift = step && !at_end &&  walk_sell;
    assign b_wr    = (b_shift && keep) || (do_rest && (r_side == lom_pkg::SIDE_BUY));
    assign s_wr    = (s_shift && keep) || (do_rest && (r_side == lom_pkg::SIDE_SELL));
    assign b_pos   = b_shift ? wpos[IW-1:0] : r_cnt_b[IW-1:0];
    assign s_pos   = s_shift ? wpos[IW-1:0] : r_cnt_s[IW-1:0];

    lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_buy (
        .i_clk(i_clk), .i_shift(b_shift), .i_wr(b_wr), .i_wr_pos(b_pos),
        .i_wr_data(b_shift ? kept : append), .o_head(head_b)
    );

    lom_book #(.BOOK_DEPTH(BOOK_DEPTH)) u_sell (
        .i_clk(i_clk), .i_shift(s_shift), .i_wr(s_wr), .i_wr_pos(s_pos),
        .i_wr_data(s_shift ? kept : append), .o_head(head_s)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_b   <= '0;
            r_cnt_s   <= '0;
            r_next_id <= 16'd1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_command;
                        r_side   <= i_side;
                        r_sym    <= i_symbol_index;
                        r_price  <= i_limit_price;
                        r_trader <= i_trader_id;
                        r_cid    <= i_cancel_id;
                        r_remain <= i_order_quantity;
                        r_phase  <= 1'b0;
                        r_found  <= 1'b0;
                        r_k      <= '0;
                        if (i_command == lom_pkg::CMD_CANCEL) begin
                            r_u     <= r_cnt_b;
                            r_state <= S_WALK;
                        end else if (i_order_quantity == '0) begin
                            r_id    <= '0;
                            r_state <= S_FINISH;
                        end else begin
                            r_id      <= r_next_id;
                            r_next_id <= r_next_id + 16'd1;
                            r_u       <= (i_side == lom_pkg::SIDE_SELL) ? r_cnt_b : r_cnt_s;
                            r_state   <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (step) begin
                        if (at_end) begin
                            // close the walk: kept entries now sit at the head
                            if (walk_sell) r_cnt_s <= r_k;
                            else           r_cnt_b <= r_k;
                            if ((r_cmd == lom_pkg::CMD_CANCEL) && !r_phase && !r_found) begin
                                r_phase <= 1'b1;
                                r_u     <= r_cnt_s;
                                r_k     <= '0;
                            end else begin
                                r_state <= S_FINISH;
                            end
                        end else begin
                            r_u <= r_u - CW'(1);
                            if (keep) r_k <= r_k + CW'(1);
                            if (match) begin
                                if (r_cmd == lom_pkg::CMD_CANCEL) begin
                                    r_found <= 1'b1;
                                    r_csym  <= head.sym;
                                    r_cqty  <= head.qty;
                                end else begin
                                    r_remain <= r_remain - n_t;
                                end
                            end
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (do_rest) begin
                            if (r_side == lom_pkg::SIDE_SELL) r_cnt_s <= r_cnt_s + CW'(1);
                            else                              r_cnt_b <= r_cnt_b + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register: load a trade or the closing answer, hold while stalled
    logic emit_fin;
    assign emit_fin = (r_state == S_FINISH) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_trade || emit_fin) begin
            r_ov <= 1'b1;
        end else if (out_free) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_trade) begin
            r_kind    <= lom_pkg::KIND_TRADE;
            r_osym    <= r_sym;
            r_oshares <= n_t;
            r_oid     <= head.id;
            r_ostatus <= lom_pkg::ST_FILLED;
            r_olast   <= 1'b0;
            if (r_side == lom_pkg::SIDE_SELL) begin
                r_buyer  <= head.trader;
                r_seller <= r_trader;
                r_oprice <= r_price;
            end else begin
                r_buyer  <= r_trader;
                r_seller <= head.trader;
                r_oprice <= head.price;
            end
        end else if (emit_fin) begin
            r_buyer  <= '0;
            r_seller <= '0;
            r_oprice <= '0;
            r_olast  <= 1'b1;
            if (r_cmd == lom_pkg::CMD_CANCEL) begin
                r_kind    <= lom_pkg::KIND_CANCEL;
                r_osym    <= r_found ? r_csym : 4'd0;
                r_oshares <= r_found ? r_cqty : 16'd0;
                r_oid     <= r_cid;
                r_ostatus <= r_found ? lom_pkg::ST_CANCELLED : lom_pkg::ST_NOT_FOUND;
            end else begin
                r_kind    <= lom_pkg::KIND_FINISH;
                r_osym    <= r_sym;
                r_oshares <= r_remain;
                r_oid     <= r_id;
                if (r_remain == '0)   r_ostatus <= lom_pkg::ST_FILLED;
                else if (do_rest)     r_ostatus <= lom_pkg::ST_RESTED;
                else                  r_ostatus <= lom_pkg::ST_DROPPED;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_result_kind  = r_kind;
    assign o_buyer_id     = r_buyer;
    assign o_seller_id    = r_seller;
    assign o_trade_symbol = r_osym;
    assign o_trade_price  = r_oprice;
    assign o_shares       = r_oshares;
    assign o_assigned_id  = r_oid;
    assign o_status       = r_ostatus;
    assign o_last_item    = r_olast;

    // checks
    a_cnt_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_b <= CW'(BOOK_DEPTH)) else $error("buy count beyond depth");
    a_cnt_s: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_s <= CW'(BOOK_DEPTH)) else $error("sell count beyond depth");
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_u + r_k) <= CW'(BOOK_DEPTH)))
        else $error("walk overruns the row");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE)) else $error("accepted item not taken up");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the limit order matcher. A local copy of both
// books predicts every trade, finish and cancel answer; results are
// compared, all fields together, in order, against the queue of predictions.
// ----------------------------------------------------------------------------
module tb;

    localparam int Depth = 32;
    localparam int CycleLimit = 400000;
    localparam int HoldCycles = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  buyer;
        logic [7:0]  seller;
        logic [3:0]  sym;
        logic [31:0] price;
        logic [15:0] shares;
        logic [15:0] id;
        logic [2:0]  status;
        logic        last;
    } t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_command = lom_pkg::CMD_PLACE;
    logic i_side = lom_pkg::SIDE_BUY;
    logic [3:0] i_symbol_index = '0;
    logic [31:0] i_limit_price = '0;
    logic [15:0] i_order_quantity = '0;
    logic [7:0] i_trader_id = '0;
    logic [15:0] i_cancel_id = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [1:0] o_result_kind;
    logic [7:0] o_buyer_id, o_seller_id;
    logic [3:0] o_trade_symbol;
    logic [31:0] o_trade_price;
    logic [15:0] o_shares, o_assigned_id;
    logic [2:0] o_status;
    logic o_last_item;

    limit_order_matcher dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the books: index 0 buy, index 1 sell.
    lom_pkg::t_entry book [2][Depth];
    int book_cnt [2];
    logic [15:0] id_next;
    t_fill expected_fills [$];

    int errors = 0;
    int cycles = 0;
    int n_trades = 0, n_finishes = 0, n_cancels = 0, n_items = 0;
    bit hold_off = 1'b0;
    event hold_go;
    int stall_pct = 30;
    logic [15:0] last_ids [$];

    function automatic void queue_fill(t_fill f);
        expected_fills = {expected_fills, f};
    endfunction

    task automatic drop_entry(int s, int pos);
        for (int j = pos; j < book_cnt[s] - 1; j++) book[s][j] = book[s][j+1];
        book_cnt[s]--;
    endtask

    task automatic predict_cancel(logic [7:0] trader, logic [15:0] cid);
        t_fill f;
        f = '0;
        f.kind = lom_pkg::KIND_CANCEL; f.id = cid; f.status = lom_pkg::ST_NOT_FOUND;
        f.last = 1'b1;
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < book_cnt[s]; i++) begin
                if (book[s][i].id == cid && book[s][i].trader == trader) begin
                    f.sym = book[s][i].sym;
                    f.shares = book[s][i].qty;
                    f.status = lom_pkg::ST_CANCELLED;
                    drop_entry(s, i);
                    queue_fill(f);
                    return;
                end
            end
        end
        queue_fill(f);
    endtask

    task automatic predict_place(logic sd, logic [3:0] sym, logic [31:0] lim,
                                 logic [15:0] qty, logic [7:0] trader);
        int opp, own, i;
        logic [15:0] left, fill_q, oid;
        logic crosses;
        t_fill f;
        f = '0;
        f.kind = lom_pkg::KIND_FINISH; f.sym = sym; f.last = 1'b1;
        if (qty == 0) begin
            f.status = lom_pkg::ST_FILLED;
            queue_fill(f);
            return;
        end
        oid = id_next;
        id_next++;
        opp = (sd == lom_pkg::SIDE_SELL) ? 0 : 1;
        own = 1 - opp;
        left = qty;
        i = 0;
        while (i < book_cnt[opp] && left > 0) begin
            crosses = (sd == lom_pkg::SIDE_SELL) ? (book[opp][i].price >= lim)
                                                 : (book[opp][i].price <= lim);
            if (book[opp][i].sym == sym && crosses && book[opp][i].qty > 0) begin
                t_fill t;
                fill_q = (left < book[opp][i].qty) ? left : book[opp][i].qty;
                t = '0;
                t.kind = lom_pkg::KIND_TRADE; t.sym = sym; t.shares = fill_q;
                t.id = book[opp][i].id; t.status = lom_pkg::ST_FILLED;
                if (sd == lom_pkg::SIDE_SELL) begin
                    t.buyer = book[opp][i].trader; t.seller = trader; t.price = lim;
                end else begin
                    t.buyer = trader; t.seller = book[opp][i].trader;
                    t.price = book[opp][i].price;
                end
                queue_fill(t);
                left -= fill_q;
                book[opp][i].qty -= fill_q;
                if (book[opp][i].qty == 0) begin
                    drop_entry(opp, i);
                    continue;
                end
            end
            i++;
        end
        f.shares = left; f.id = oid;
        if (left == 0) begin
            f.status = lom_pkg::ST_FILLED;
        end else if (book_cnt[own] < Depth) begin
            book[own][book_cnt[own]] = '{price: lim, qty: left, trader: trader,
                                         sym: sym, id: oid};
            book_cnt[own]++;
            f.status = lom_pkg::ST_RESTED;
            last_ids = {last_ids, oid};
        end else begin
            f.status = lom_pkg::ST_DROPPED;
        end
        queue_fill(f);
    endtask

    // Present one item, wait for its transfer, then predict its results.
    task automatic send_item(logic cmd, logic sd, logic [3:0] sym, logic [31:0] lim,
                             logic [15:0] qty, logic [7:0] trader, logic [15:0] cid);
        i_in_valid <= 1'b1;
        i_command <= cmd; i_side <= sd; i_symbol_index <= sym;
        i_limit_price <= lim; i_order_quantity <= qty;
        i_trader_id <= trader; i_cancel_id <= cid;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (cmd == lom_pkg::CMD_CANCEL) predict_cancel(trader, cid);
        else predict_place(sd, sym, lim, qty, trader);
    endtask

    task automatic idle_cycles(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic place(logic sd, logic [3:0] sym, logic [31:0] lim,
                         logic [15:0] qty, logic [7:0] trader);
        send_item(lom_pkg::CMD_PLACE, sd, sym, lim, qty, trader, 16'($urandom));
    endtask

    task automatic cancel(logic [7:0] trader, logic [15:0] cid);
        send_item(lom_pkg::CMD_CANCEL, 1'($urandom), 4'($urandom), $urandom,
                  16'($urandom), trader, cid);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_fills.size() != 0) @(posedge i_clk);
        repeat (Depth * 2 + 8) @(posedge i_clk);
    endtask

    // Field extremes, both trade-price rules, zero quantity, cancels.
    task automatic test_directed();
        place(lom_pkg::SIDE_SELL, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        place(lom_pkg::SIDE_BUY, 4'd15, 32'hFFFF_FFFF, 16'd1, 8'h00);
        place(lom_pkg::SIDE_BUY, 4'd0, 32'd1, 16'd0, 8'hAA);
        place(lom_pkg::SIDE_SELL, 4'd3, 32'd100, 16'd5, 8'd1);
        place(lom_pkg::SIDE_SELL, 4'd3, 32'd90, 16'd7, 8'd2);
        place(lom_pkg::SIDE_SELL, 4'd4, 32'd50, 16'd7, 8'd2);
        place(lom_pkg::SIDE_BUY, 4'd3, 32'd120, 16'd20, 8'd9);
        place(lom_pkg::SIDE_BUY, 4'd3, 32'd80, 16'd10, 8'd4);
        place(lom_pkg::SIDE_BUY, 4'd3, 32'd85, 16'd3, 8'd5);
        place(lom_pkg::SIDE_SELL, 4'd3, 32'd70, 16'd30, 8'd6);
        place(lom_pkg::SIDE_BUY, 4'd0, 32'd1, 16'd1, 8'd7);
        cancel(8'd2, 16'd6);
        cancel(8'd3, 16'd1);
        cancel(8'hFF, 16'd1);
        cancel(8'd0, 16'hFFFF);
        place(lom_pkg::SIDE_SELL, 4'd0, 32'd1, 16'd1, 8'd0);
        drain();
    endtask

    // Fill the buy book past its depth so the remainder is dropped.
    task automatic test_book_full();
        for (int k = 0; k < Depth + 3; k++)
            place(lom_pkg::SIDE_BUY, 4'd8, 32'd10 + k, 16'($urandom_range(1, 50)),
                  8'($urandom));
        place(lom_pkg::SIDE_SELL, 4'd8, 32'd1, 16'hFFFF, 8'd77);
        drain();
    endtask

    // Receiver holds off for a long stretch while orders keep arriving.
    task automatic test_back_pressure();
        -> hold_go;
        for (int k = 0; k < 20; k++)
            place(k[0], 4'd2, $urandom_range(90, 110), 16'($urandom_range(1, 40)),
                  8'($urandom));
        drain();
    endtask

    // Random order flow on few symbols and a narrow price band so books cross.
    task automatic test_random_flow(int count);
        int burst;
        logic [15:0] cid;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && count > 0; k++, count--) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        cid = (last_ids.size() != 0 && $urandom_range(0, 3) != 0)
                            ? last_ids[$urandom_range(0, last_ids.size() - 1)]
                            : 16'($urandom);
                        cancel(8'($urandom_range(0, 3) == 0 ? $urandom
                                                            : $urandom_range(0, 7)),
                               cid);
                    end
                    2: send_item(1'($urandom), 1'($urandom), 4'($urandom), $urandom,
                                 16'($urandom), 8'($urandom), 16'($urandom));
                    default: place(1'($urandom), 4'($urandom_range(0, 2)),
                                   32'd1000 + $urandom_range(0, 40),
                                   $urandom_range(0, 20) == 0
                                       ? 16'd0 : 16'($urandom_range(1, 60)),
                                   8'($urandom_range(0, 7)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
        end
        drain();
    endtask

    // Empty both books by cancel, then rest one order and cancel it.
    task automatic test_clear_books();
        for (int s = 0; s < 2; s++) begin
            while (book_cnt[s] > 0) cancel(book[s][0].trader, book[s][0].id);
        end
        drain();
        place(lom_pkg::SIDE_BUY, 4'd1, 32'd5, 16'd3, 8'd3);
        cancel(8'd3, id_next - 16'd1);
        drain();
    endtask

    // Long hold-off, counted here in cycles once requested.
    always begin
        @(hold_go);
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Receiver stall pattern: long hold-off on request, regular stall-free stretches, otherwise random.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_off) i_out_stall <= 1'b1;
        else if ((cycles / 200) % 4 == 3) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Compare each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_fill got, want;
            got = '{o_result_kind, o_buyer_id, o_seller_id, o_trade_symbol,
                    o_trade_price, o_shares, o_assigned_id, o_status, o_last_item};
            if (expected_fills.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h", $time, got);
            end else begin
                want = expected_fills.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                end
                case (got.kind)
                    lom_pkg::KIND_TRADE: n_trades++;
                    lom_pkg::KIND_FINISH: n_finishes++;
                    default: n_cancels++;
                endcase
            end
        end
    end

    initial begin
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        id_next = 16'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_book_full();
        test_back_pressure();
        test_random_flow(200);
        stall_pct = 70;
        test_random_flow(150);
        stall_pct = 10;
        test_clear_books();
        if (expected_fills.size() != 0) errors++;
        $display("covered %0d items: %0d trades, %0d finishes, %0d cancel answers",
                 n_items, n_trades, n_finishes, n_cancels);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: limit_order_matcher.f
rtl/lom_pkg.sv
rtl/lom_cell.sv
rtl/lom_book.sv
rtl/limit_order_matcher.sv
tb/sv/tb.sv
